/* rtl/core/rsef_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package rsef_pkg;

  localparam int DEF_MAX_READINGS = 128;
  localparam int DEF_MAX_RESULTS  = 64;

  localparam int ANGLE_W = 16;
  localparam int DIST_W  = 12;
  localparam int KIND_W  = 2;
  localparam int INDEX_W = 7;
  localparam int SUM_W   = DIST_W + 3;
  localparam int PROD_W  = 31;

  localparam logic [DIST_W-1:0] THR_RESET = 12'd2240;

  // floor(x / 5) == (x * 52429) >> 18 for every five-reading sum.
  localparam logic [15:0] DIV5_MUL   = 16'd52429;
  localparam int          DIV5_SHIFT = 18;

  localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_MIN  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_GAP  = 2'd2;

  typedef struct packed {
    logic load;
    logic sm_init;
    logic sm_run;
    logic sc_init;
    logic sc_run;
    logic sc_gap;
    logic fin;
    logic em_init;
    logic em_rd;
    logic em_rd2;
    logic em_ld;
  } cmd_t;

  typedef struct packed {
    logic sm_done;
    logic sc_done;
    logic out_free;
    logic em_last;
  } sts_t;

endpackage
`default_nettype wire

/* rtl/core/rsef_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module rsef_ctrl
  import rsef_pkg::*;
(
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_valid,
  input  wire  in_last,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] ST_LOAD = 4'd0;
  localparam logic [3:0] ST_SMI  = 4'd1;
  localparam logic [3:0] ST_SMO  = 4'd2;
  localparam logic [3:0] ST_MNI  = 4'd3;
  localparam logic [3:0] ST_MNS  = 4'd4;
  localparam logic [3:0] ST_GPI  = 4'd5;
  localparam logic [3:0] ST_GPS  = 4'd6;
  localparam logic [3:0] ST_FIN  = 4'd7;
  localparam logic [3:0] ST_EMI  = 4'd8;
  localparam logic [3:0] ST_ERD  = 4'd9;
  localparam logic [3:0] ST_ERD2 = 4'd10;
  localparam logic [3:0] ST_ELD  = 4'd11;

  logic [3:0] state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_LOAD: begin
        cmd.load = 1'b1;
        if (in_valid && in_last) begin
          state_nxt = ST_SMI;
        end
      end
      ST_SMI: begin
        cmd.sm_init = 1'b1;
        state_nxt   = ST_SMO;
      end
      ST_SMO: begin
        cmd.sm_run = 1'b1;
        if (sts.sm_done) begin
          state_nxt = ST_MNI;
        end
      end
      ST_MNI: begin
        cmd.sc_init = 1'b1;
        state_nxt   = ST_MNS;
      end
      ST_MNS: begin
        cmd.sc_run = 1'b1;
        if (sts.sc_done) begin
          state_nxt = ST_GPI;
        end
      end
      ST_GPI: begin
        cmd.sc_init = 1'b1;
        cmd.sc_gap  = 1'b1;
        state_nxt   = ST_GPS;
      end
      ST_GPS: begin
        cmd.sc_run = 1'b1;
        cmd.sc_gap = 1'b1;
        if (sts.sc_done) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.fin   = 1'b1;
        state_nxt = ST_EMI;
      end
      ST_EMI: begin
        cmd.em_init = 1'b1;
        state_nxt   = ST_ERD;
      end
      ST_ERD: begin
        cmd.em_rd = 1'b1;
        state_nxt = ST_ERD2;
      end
      ST_ERD2: begin
        cmd.em_rd2 = 1'b1;
        state_nxt  = ST_ELD;
      end
      ST_ELD: begin
        cmd.em_ld = 1'b1;
        if (sts.out_free) begin
          state_nxt = sts.em_last ? ST_LOAD : ST_ERD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

endmodule
`default_nettype wire

/* rtl/core/rsef_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
module rsef_datapath
  import rsef_pkg::*;
#(
  parameter int MAX_READINGS = DEF_MAX_READINGS,
  parameter int MAX_RESULTS  = DEF_MAX_RESULTS
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  cmd_t                      cmd,
  output sts_t                      sts,
  input  wire                       in_valid,
  input  wire signed [ANGLE_W-1:0]  in_angle,
  input  wire        [DIST_W-1:0]   in_distance,
  input  wire                       in_last,
  input  wire                       cfg_we,
  input  wire        [DIST_W-1:0]   cfg_wdata,
  output logic                      out_valid,
  input  wire                       out_stall,
  output logic       [KIND_W-1:0]   out_kind,
  output logic       [INDEX_W-1:0]  out_index,
  output logic signed [ANGLE_W-1:0] out_angle_res,
  output logic       [DIST_W-1:0]   out_distance_res,
  output logic                      out_truncated,
  output logic                      out_last_res
);

  localparam int AW   = $clog2(MAX_READINGS);
  localparam int NW   = $clog2(MAX_READINGS + 1);
  localparam int KW   = $clog2(MAX_READINGS + 5);
  localparam int CNTW = $clog2(2 * MAX_READINGS + 3);
  localparam int RW   = $clog2(MAX_RESULTS + 1);
  localparam int PW   = $clog2(MAX_RESULTS + 2);
  localparam int XW   = (CNTW > PW) ? CNTW : PW;
  localparam int CEW  = KIND_W + AW;

  // Scan storage.
  logic        [DIST_W-1:0]  raw_mem [MAX_READINGS];
  logic        [DIST_W-1:0]  sm_mem  [MAX_READINGS];
  logic signed [ANGLE_W-1:0] ang_mem [MAX_READINGS];
  logic        [CEW-1:0]     cmem    [MAX_RESULTS + 1];

  logic [DIST_W-1:0] thr_r;
  logic [NW-1:0]     cnt_r;
  logic [NW-1:0]     n_r;

  // Pass counters and read pipeline.
  logic [KW-1:0]     ki_r;
  logic [AW-1:0]     ra_r;
  logic [AW-1:0]     wa_r;
  logic [NW-1:0]     wc_r;
  logic [NW-1:0]     sa_r;
  logic              rv_r;
  logic [KW-1:0]     rk_r;
  logic [DIST_W-1:0] raw_q_r;
  logic [DIST_W-1:0] sm_q_r;
  logic signed [ANGLE_W-1:0] ang_q_r;
  logic [DIST_W-1:0] win_r [4];
  logic [SUM_W-1:0]  sum_r;
  logic              sv_r;

  // Gap tracking.
  logic          started_r;
  logic [AW-1:0] start_r;
  logic [AW-1:0] end_r;
  logic          fz_r;
  logic [AW-1:0] fze_r;
  logic          drop_r;
  logic [AW-1:0] mrg_r;

  // Candidate list and emission.
  logic [CNTW-1:0]   cand_cnt_r;
  logic [CNTW-1:0]   gap_base_r;
  logic [RW-1:0]     k_r;
  logic [PW-1:0]     p_r;
  logic [CEW-1:0]    cq_r;
  logic              use_mrg_r;
  logic [KIND_W-1:0] sel_kind_r;
  logic [AW-1:0]     sel_idx_r;
  logic              out_valid_r;

  logic              acc, room;
  logic [NW-1:0]     cnt_inc;
  logic              sm_issue, sc_issue;
  logic [AW-1:0]     e;
  logic              is_open;
  logic              mn_hit, g_close, f_open;
  logic [AW-1:0]     mid_cur;
  logic              cw_en;
  logic [KIND_W-1:0] cw_kind;
  logic [AW-1:0]     cw_idx;
  logic [AW:0]       mrg_sum, mrg_t;
  logic [PROD_W-1:0] prod;
  logic [DIST_W-1:0] quot;
  logic [PW-1:0]     c_addr;
  logic [RW-1:0]     emit_n;
  logic              trunc;
  logic [KIND_W-1:0] sel_kind;
  logic [AW-1:0]     sel_idx;
  logic [AW-1:0]     sm_ra;
  logic [AW-1:0]     ang_ra;
  logic              out_free;

  always_comb begin
    acc      = cmd.load && in_valid;
    room     = cnt_r < NW'(MAX_READINGS);
    cnt_inc  = room ? cnt_r + NW'(1) : cnt_r;
    sm_issue = cmd.sm_run && (ki_r < KW'(n_r) + KW'(4));
    sc_issue = cmd.sc_run && (sa_r < n_r);
    e        = rk_r[AW-1:0];
    is_open  = sm_q_r >= thr_r;

    mn_hit = cmd.sc_run && !cmd.sc_gap && rv_r && (rk_r >= KW'(4)) &&
             (win_r[0] > win_r[1]) && (win_r[1] > win_r[2]) &&
             (win_r[2] < win_r[3]) && (win_r[3] < sm_q_r);
    g_close = cmd.sc_run && cmd.sc_gap && rv_r && started_r && !is_open;
    f_open  = cmd.fin && started_r && !fz_r;
    mid_cur = start_r + ((end_r - start_r) >> 1);

    cw_en   = mn_hit || g_close || f_open;
    cw_kind = mn_hit ? KIND_MIN : KIND_GAP;
    cw_idx  = mn_hit ? e - AW'(2) : mid_cur;

    // Gap open at the end joined to the gap that started at index 0.
    mrg_sum = (AW + 1)'(end_r) + (AW + 1)'(fze_r) - (AW + 1)'(start_r);
    mrg_t   = (AW + 1)'(start_r) + (mrg_sum >> 1);

    prod = PROD_W'(sum_r) * PROD_W'(DIV5_MUL);
    quot = prod[DIV5_SHIFT +: DIST_W];

    c_addr = (drop_r && (XW'(p_r) == XW'(gap_base_r))) ? p_r + PW'(1) : p_r;
    trunc  = cand_cnt_r > CNTW'(MAX_RESULTS);
    emit_n = trunc ? RW'(MAX_RESULTS) : RW'(cand_cnt_r);

    sel_kind = use_mrg_r ? KIND_GAP : cq_r[CEW-1 -: KIND_W];
    sel_idx  = use_mrg_r ? mrg_r : cq_r[AW-1:0];
    sm_ra    = cmd.sc_run ? sa_r[AW-1:0] : (cmd.em_rd2 ? sel_idx : sel_idx_r);
    ang_ra   = cmd.em_rd2 ? sel_idx : sel_idx_r;

    out_free = !out_valid_r || !out_stall;

    sts.sm_done  = wc_r == n_r;
    sts.sc_done  = (sa_r == n_r) && !rv_r;
    sts.out_free = out_free;
    sts.em_last  = (cand_cnt_r == '0) || (k_r == emit_n - RW'(1));
  end

  // Memories.
  always_ff @(posedge clk) begin
    if (acc && room) begin
      raw_mem[cnt_r[AW-1:0]] <= in_distance;
      ang_mem[cnt_r[AW-1:0]] <= in_angle;
    end
    if (sv_r) begin
      sm_mem[wa_r] <= quot;
    end
    if (cw_en && (cand_cnt_r <= CNTW'(MAX_RESULTS))) begin
      cmem[cand_cnt_r[RW-1:0]] <= {cw_kind, cw_idx};
    end
    raw_q_r <= raw_mem[ra_r];
    sm_q_r  <= sm_mem[sm_ra];
    ang_q_r <= ang_mem[ang_ra];
    cq_r    <= cmem[c_addr[RW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= THR_RESET;
      cnt_r       <= '0;
      n_r         <= '0;
      rv_r        <= 1'b0;
      sv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      started_r   <= 1'b0;
      fz_r        <= 1'b0;
      drop_r      <= 1'b0;
      cand_cnt_r  <= '0;
    end else begin
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      if (acc) begin
        if (in_last) begin
          n_r   <= cnt_inc;
          cnt_r <= '0;
        end else begin
          cnt_r <= cnt_inc;
        end
      end

      rv_r <= sm_issue || sc_issue;
      sv_r <= cmd.sm_run && rv_r && (rk_r >= KW'(4));

      if (cmd.sc_init) begin
        started_r <= 1'b0;
        fz_r      <= 1'b0;
        if (!cmd.sc_gap) begin
          drop_r     <= 1'b0;
          cand_cnt_r <= '0;
        end
      end
      if (cw_en) begin
        cand_cnt_r <= cand_cnt_r + CNTW'(1);
      end
      if (cmd.sc_run && cmd.sc_gap && rv_r) begin
        if (started_r) begin
          if (!is_open) begin
            started_r <= 1'b0;
            if (start_r == '0) begin
              fz_r <= 1'b1;
            end
          end
        end else if (is_open) begin
          started_r <= 1'b1;
        end
      end
      if (cmd.fin && started_r && fz_r) begin
        drop_r <= 1'b1;
      end

      if (cmd.em_ld && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Counters and payload.
  always_ff @(posedge clk) begin
    if (cmd.sm_init) begin
      ki_r <= '0;
      ra_r <= '0;
      wc_r <= '0;
      wa_r <= (n_r > NW'(2)) ? AW'(2) : '0;
    end
    if (sm_issue) begin
      ki_r <= ki_r + KW'(1);
      ra_r <= (NW'(ra_r) == n_r - NW'(1)) ? '0 : ra_r + AW'(1);
    end
    if (sv_r) begin
      wc_r <= wc_r + NW'(1);
      wa_r <= (NW'(wa_r) == n_r - NW'(1)) ? '0 : wa_r + AW'(1);
    end
    if (cmd.sc_init) begin
      sa_r <= '0;
    end
    if (sc_issue) begin
      sa_r <= sa_r + NW'(1);
    end
    rk_r <= cmd.sc_run ? KW'(sa_r) : ki_r;

    if (rv_r) begin
      win_r[0] <= win_r[1];
      win_r[1] <= win_r[2];
      win_r[2] <= win_r[3];
      win_r[3] <= cmd.sc_run ? sm_q_r : raw_q_r;
    end
    sum_r <= SUM_W'(win_r[0]) + SUM_W'(win_r[1]) + SUM_W'(win_r[2]) +
             SUM_W'(win_r[3]) + SUM_W'(raw_q_r);

    if (cmd.sc_init && cmd.sc_gap) begin
      fze_r      <= '0;
      gap_base_r <= cand_cnt_r;
    end
    if (cmd.sc_run && cmd.sc_gap && rv_r) begin
      if (started_r) begin
        if (is_open) begin
          end_r <= e;
        end else if (start_r == '0) begin
          fze_r <= end_r;
        end
      end else if (is_open) begin
        start_r <= e;
        end_r   <= e;
      end
    end
    if (cmd.fin) begin
      mrg_r <= AW'((mrg_t >= (AW + 1)'(n_r)) ? mrg_t - (AW + 1)'(n_r) : mrg_t);
    end

    if (cmd.em_init) begin
      k_r <= '0;
      p_r <= '0;
    end
    if (cmd.em_rd) begin
      p_r       <= c_addr + PW'(1);
      use_mrg_r <= drop_r && (XW'(k_r) == XW'(cand_cnt_r - CNTW'(1)));
    end
    if (cmd.em_rd2) begin
      sel_kind_r <= sel_kind;
      sel_idx_r  <= sel_idx;
    end
    if (cmd.em_ld && out_free) begin
      k_r <= k_r + RW'(1);
      if (cand_cnt_r == '0) begin
        out_kind         <= KIND_NONE;
        out_index        <= '0;
        out_angle_res    <= '0;
        out_distance_res <= '0;
        out_truncated    <= 1'b0;
        out_last_res     <= 1'b1;
      end else begin
        out_kind         <= sel_kind_r;
        out_index        <= INDEX_W'(sel_idx_r);
        out_angle_res    <= ang_q_r;
        out_distance_res <= sm_q_r;
        out_truncated    <= trunc;
        out_last_res     <= sts.em_last;
      end
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

/* rtl/core/range_scan_extrema_finder.sv */
`timescale 1ns / 1ps
`default_nettype none
// Takes one scan reading per cycle until the reading marked last. Then the
// stored scan of n readings is smoothed and read twice, once for local
// minima and once for open gaps; every result then steps through a read, a
// second read and an output load, and waits while the output is stalled.
// Each scan memory has a single read port. The last result may wait in the
// output register while the next scan loads.
module range_scan_extrema_finder
  import rsef_pkg::*;
#(
  parameter int MAX_READINGS = DEF_MAX_READINGS,
  parameter int MAX_RESULTS  = DEF_MAX_RESULTS
) (
  input  wire                        clk,
  input  wire                        rst_n,
  input  wire                        in_valid,
  output logic                       in_stall,
  input  wire signed [ANGLE_W-1:0]   in_angle,
  input  wire        [DIST_W-1:0]    in_distance,
  input  wire                        in_last,
  output logic                       out_valid,
  input  wire                        out_stall,
  output logic       [KIND_W-1:0]    out_kind,
  output logic       [INDEX_W-1:0]   out_index,
  output logic signed [ANGLE_W-1:0]  out_angle_res,
  output logic       [DIST_W-1:0]    out_distance_res,
  output logic                       out_truncated,
  output logic                       out_last_res,
  input  wire                        cfg_we,
  input  wire        [DIST_W-1:0]    cfg_wdata
);

  cmd_t cmd;
  sts_t sts;

  rsef_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_last  (in_last),
    .sts      (sts),
    .cmd      (cmd)
  );

  rsef_datapath #(
    .MAX_READINGS (MAX_READINGS),
    .MAX_RESULTS  (MAX_RESULTS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_valid         (in_valid),
    .in_angle         (in_angle),
    .in_distance      (in_distance),
    .in_last          (in_last),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_index        (out_index),
    .out_angle_res    (out_angle_res),
    .out_distance_res (out_distance_res),
    .out_truncated    (out_truncated),
    .out_last_res     (out_last_res)
  );

  assign in_stall = !cmd.load;

  // No request is taken while a pass runs over the stored scan.
  a_no_load_in_pass: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !cmd.sm_run && !cmd.sc_run && !cmd.em_ld)
    else $error("request accepted during a scan pass");

  // A loaded result shows up on the output in the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.em_ld && sts.out_free |=> out_valid)
    else $error("loaded result not presented");

  // The controller runs at most one phase at a time.
  a_one_phase: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.sm_run, cmd.sc_run, cmd.fin, cmd.em_rd, cmd.em_ld}))
    else $error("overlapping controller phases");

endmodule
`default_nettype wire
